### rtl/ptcrc_pkg.sv
// Shared types and constants for the parameterized table-free CRC engine.
// No dependencies; imported by every module in this folder.
package ptcrc_pkg;

  localparam int BYTE_W        = 8;
  localparam int CRC_VALUE_W   = 64;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_INDEX_W   = 3;
  localparam int WIDTH_SEL_W   = 2;
  localparam int MAX_WIDTH_DEF = 64;

  // Register map of the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_WIDTH_SEL  = 3'd0,
    CFG_POLYNOMIAL = 3'd1,
    CFG_INIT_VALUE = 3'd2,
    CFG_REFLECT    = 3'd3,
    CFG_FINAL_XOR  = 3'd4
  } cfg_index_t;

  // Reset values of the configuration registers (CRC-32 as default).
  localparam logic [WIDTH_SEL_W-1:0] RESET_WIDTH_SEL  = 2'd2;
  localparam logic [CFG_DATA_W-1:0]  RESET_POLYNOMIAL = 64'h0000_0000_04C1_1DB7;
  localparam logic [CFG_DATA_W-1:0]  RESET_INIT_VALUE = 64'h0000_0000_FFFF_FFFF;
  localparam logic                   RESET_REFLECT    = 1'b1;
  localparam logic [CFG_DATA_W-1:0]  RESET_FINAL_XOR  = 64'h0000_0000_FFFF_FFFF;

  // Per-byte control handed to the update logic.
  typedef struct packed {
    logic [WIDTH_SEL_W-1:0] width_sel;
    logic                   reflect;
    logic                   start;
  } step_ctrl_t;

endpackage

### rtl/ptcrc_step.sv
// One-byte CRC update: width masking, bit reversal and eight unrolled shift/xor steps.
// Depends on ptcrc_pkg.
module ptcrc_step import ptcrc_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  step_ctrl_t             ctrl,
  input  logic [MAX_WIDTH-1:0]   polynomial,
  input  logic [MAX_WIDTH-1:0]   init_value,
  input  logic [MAX_WIDTH-1:0]   final_xor,
  input  logic [MAX_WIDTH-1:0]   crc_in,
  input  logic [BYTE_W-1:0]      data_byte,
  output logic [MAX_WIDTH-1:0]   crc_next,
  output logic [MAX_WIDTH-1:0]   result
);

  // Largest width code whose width still fits in MAX_WIDTH.
  localparam int MAX_SEL = (MAX_WIDTH >= 64) ? 3 : (MAX_WIDTH >= 32) ? 2 :
                           (MAX_WIDTH >= 16) ? 1 : 0;

  logic [WIDTH_SEL_W-1:0] eff_sel;
  logic [6:0]             wbits;
  logic [6:0]             rev_shift;
  logic [6:0]             top_shift;
  logic [MAX_WIDTH-1:0]   mask;
  logic [MAX_WIDTH-1:0]   msb;
  logic [MAX_WIDTH-1:0]   poly_m;
  logic [MAX_WIDTH-1:0]   init_m;
  logic [MAX_WIDTH-1:0]   poly_rev_full;
  logic [MAX_WIDTH-1:0]   init_rev_full;
  logic [MAX_WIDTH-1:0]   rpoly;
  logic [MAX_WIDTH-1:0]   init_load;
  logic [MAX_WIDTH-1:0]   reg_cur;
  logic [MAX_WIDTH-1:0]   byte_ext;
  logic [MAX_WIDTH-1:0]   t;

  assign eff_sel   = (ctrl.width_sel > WIDTH_SEL_W'(MAX_SEL)) ? WIDTH_SEL_W'(MAX_SEL)
                                                               : ctrl.width_sel;
  assign wbits     = 7'd8 << eff_sel;
  assign rev_shift = 7'(MAX_WIDTH) - wbits;
  assign top_shift = wbits - 7'd8;
  assign byte_ext  = MAX_WIDTH'(data_byte);

  always_comb begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      mask[i] = (7'(i) < wbits);
    end
    msb    = MAX_WIDTH'(1) << (wbits - 7'd1);
    poly_m = polynomial & mask;
    init_m = init_value & mask;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      poly_rev_full[i] = poly_m[MAX_WIDTH-1-i];
      init_rev_full[i] = init_m[MAX_WIDTH-1-i];
    end
    // Reverse within the active width: full reverse, then drop the unused low end.
    rpoly     = poly_rev_full >> rev_shift;
    init_load = ctrl.reflect ? (init_rev_full >> rev_shift) : init_m;
    reg_cur   = (ctrl.start ? init_load : crc_in) & mask;

    if (ctrl.reflect) begin
      t = (reg_cur ^ byte_ext) & MAX_WIDTH'(8'hff);
      for (int j = 0; j < 8; j++) begin
        t = t[0] ? ((t >> 1) ^ rpoly) : (t >> 1);
      end
      crc_next = ((reg_cur >> 8) ^ t) & mask;
    end else begin
      t = (((reg_cur >> top_shift) ^ byte_ext) & MAX_WIDTH'(8'hff)) << top_shift;
      for (int j = 0; j < 8; j++) begin
        t = (|(t & msb)) ? (((t << 1) ^ poly_m) & mask) : ((t << 1) & mask);
      end
      crc_next = (((reg_cur << 8) & mask) ^ t) & mask;
    end
    result = (crc_next ^ final_xor) & mask;
  end

endmodule

### rtl/parameterized_table_crc.sv
// Top level of the parameterized byte-wise CRC engine (8/16/32/64 bit).
// Depends on ptcrc_pkg and ptcrc_step.
//
// Byte-wise CRC in the classic parameterized model: width, polynomial, init,
// reflect and final-xor come from the configuration port (cfg_valid/cfg_ready,
// always ready). Each transfer on the input channel carries one byte;
// start_req=1 reloads the CRC register from init_value (bit-reversed within
// the width in reflected mode) before that byte is folded in. Every input byte
// yields exactly one output transfer carrying (register ^ final_xor) masked to
// the active width, upper bits zero. Throughput is one byte per clock while
// the output is not stalled: the byte sits in an input register, the full
// eight-step update is formed by combinational logic in ptcrc_step, and the
// result lands in the output register in the same cycle the CRC register
// advances. Output valid rises when the byte moves from the input register
// into the output register. While a result waits, one more byte
// is taken into the input register if it is empty; after that the input
// stalls until the result transfers. Widths above MAX_WIDTH fall back by
// halving. Change the configuration only while no byte is in flight.
module parameterized_table_crc import ptcrc_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  // byte input channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [BYTE_W-1:0]        data_byte,
  input  logic                     start_req,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [CRC_VALUE_W-1:0]   crc_value
);

  // Configuration registers; only the low MAX_WIDTH bits are ever used.
  logic [WIDTH_SEL_W-1:0] width_sel;
  logic [MAX_WIDTH-1:0]   polynomial;
  logic [MAX_WIDTH-1:0]   init_value;
  logic                   reflect;
  logic [MAX_WIDTH-1:0]   final_xor;

  // Input register stage.
  logic                   s1_valid;
  logic [BYTE_W-1:0]      s1_byte;
  logic                   s1_start;

  // Running CRC state.
  logic [MAX_WIDTH-1:0]   crc_register;

  logic                   s1_move;
  logic                   in_xfer;
  logic                   cfg_xfer;
  step_ctrl_t             ctrl;
  logic [MAX_WIDTH-1:0]   crc_next;
  logic [MAX_WIDTH-1:0]   result;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  // Advance the input register whenever the output register is free or draining.
  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_move;
  assign in_xfer  = in_valid && in_ready;

  assign ctrl.width_sel = width_sel;
  assign ctrl.reflect   = reflect;
  assign ctrl.start     = s1_start;

  ptcrc_step #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_step (
    .ctrl       (ctrl),
    .polynomial (polynomial),
    .init_value (init_value),
    .final_xor  (final_xor),
    .crc_in     (crc_register),
    .data_byte  (s1_byte),
    .crc_next   (crc_next),
    .result     (result)
  );

  // Configuration writes; indexes beyond the map are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_sel  <= RESET_WIDTH_SEL;
      polynomial <= RESET_POLYNOMIAL[MAX_WIDTH-1:0];
      init_value <= RESET_INIT_VALUE[MAX_WIDTH-1:0];
      reflect    <= RESET_REFLECT;
      final_xor  <= RESET_FINAL_XOR[MAX_WIDTH-1:0];
    end else if (cfg_xfer) begin
      unique case (cfg_index)
        CFG_WIDTH_SEL:  width_sel  <= cfg_data[WIDTH_SEL_W-1:0];
        CFG_POLYNOMIAL: polynomial <= cfg_data[MAX_WIDTH-1:0];
        CFG_INIT_VALUE: init_value <= cfg_data[MAX_WIDTH-1:0];
        CFG_REFLECT:    reflect    <= cfg_data[0];
        CFG_FINAL_XOR:  final_xor  <= cfg_data[MAX_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Control: input and output valid flags, CRC state.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
      crc_register <= '0;
    end else begin
      if (in_xfer) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid    <= 1'b1;
        crc_register <= crc_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: hold the byte until it moves on, hold the result until taken.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte  <= data_byte;
      s1_start <= start_req;
    end
    if (s1_move) begin
      crc_value <= CRC_VALUE_W'(result);
    end
  end

endmodule

### rtl/ptcrc_checker.sv
// Port-level checker for parameterized_table_crc, attached by bind.
// Depends on ptcrc_pkg.
module ptcrc_checker import ptcrc_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    cfg_valid,
  input logic                    cfg_ready,
  input logic [CFG_INDEX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0]   cfg_data,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [CRC_VALUE_W-1:0]  crc_value
);

  logic [WIDTH_SEL_W-1:0] shadow_sel;
  logic [1:0]             pending;
  logic                   in_xfer;
  logic                   out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Track the width code and the bytes accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      shadow_sel <= RESET_WIDTH_SEL;
      pending    <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index == CFG_WIDTH_SEL) begin
        shadow_sel <= cfg_data[WIDTH_SEL_W-1:0];
      end
      if (in_xfer && !out_xfer) begin
        pending <= pending + 2'd1;
      end else if (out_xfer && !in_xfer) begin
        pending <= pending - 2'd1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(crc_value))
    else $error("result changed or dropped while stalled");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("result presented with no byte outstanding");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending == 2'd3 || (pending == 2'd2 && in_xfer && !out_xfer) |-> 1'b0)
    else $error("more bytes in flight than the two pipeline registers hold");

  a_width_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid && (shadow_sel == 2'd0 || shadow_sel == 2'd1) |->
      crc_value[CRC_VALUE_W-1:16] == '0 &&
      (shadow_sel != 2'd0 || crc_value[15:8] == 8'h00))
    else $error("result bits above the active width are not zero");

endmodule

bind parameterized_table_crc ptcrc_checker u_ptcrc_checker (.*);
